// ===== src/sps_pkg.sv =====
// sps_pkg: shared types and constants of the servo pulse sequencer
// used by servo_pulse_sequencer and sps_checker, no dependencies
package sps_pkg;

  localparam int unsigned LineW      = 6;
  localparam int unsigned ChIdxW     = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned NumWidthRegs = 6;

  localparam logic [CfgDataW-1:0] DefaultPeriod = 16'd20000;
  localparam logic [CfgDataW-1:0] DefaultWidth  = 16'd1500;
  localparam logic [ChIdxW-1:0]   DefaultCount  = 3'd0;

  // configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_FRAME_PERIOD  = 3'd1,
    REG_WIDTH_CH0     = 3'd2,
    REG_WIDTH_CH1     = 3'd3,
    REG_WIDTH_CH2     = 3'd4,
    REG_WIDTH_CH3     = 3'd5,
    REG_WIDTH_CH4     = 3'd6,
    REG_WIDTH_CH5     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [LineW-1:0]  servo_lines;
    logic [ChIdxW-1:0] active_channel;
    logic              frame_start;
    logic              train_done;
  } result_t;

endpackage

// ===== src/servo_pulse_sequencer.sv =====
// servo_pulse_sequencer: sequential rc servo pulse train generator, one tick per request
// depends on sps_pkg
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+----------------------------------------
//   input     | in        | in_valid_i/in_stall_o | tick_i
//   output    | out       | out_valid_o/out_stall_i | servo_lines_o, active_channel_o,
//             |           |                       | frame_start_o, train_done_o
//   config    | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one request is taken per cycle while in_stall_o is low; its result is registered
// the sequencer state and the result register update in the same cycle, so the rate is set
// only by the output handshake: a two-entry output stage (output register plus skid)
// keeps input and output apart, in_stall_o rises only while both entries are full
// reset (rst_ni low, asynchronous) clears the state to the idle train-done condition and
// loads the default configuration; no clearing pass is needed
module servo_pulse_sequencer #(
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input requests
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       tick_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sps_pkg::LineW-1:0]  servo_lines_o,
  output logic [sps_pkg::ChIdxW-1:0] active_channel_o,
  output logic                       frame_start_o,
  output logic                       train_done_o,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [sps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sps_pkg::CfgDataW-1:0] cfg_data_i
);
  import sps_pkg::*;

  // wide enough for the period or width (16 bits) and for 2^COUNTER_BITS
  localparam int unsigned ExtW = (COUNTER_BITS + 1 > CfgDataW + 1) ? COUNTER_BITS + 1
                                                                   : CfgDataW + 1;
  localparam logic [ExtW-1:0] CntCap = ExtW'(1) << COUNTER_BITS;
  localparam logic [ChIdxW-1:0] MaxChannels = ChIdxW'(NUM_CHANNELS);

  // configuration registers
  logic [ChIdxW-1:0]   chan_count_q;
  logic [CfgDataW-1:0] frame_period_q;
  logic [CfgDataW-1:0] width_q [NumWidthRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q   <= DefaultCount;
      frame_period_q <= DefaultPeriod;
      for (int i = 0; i < NumWidthRegs; i++) begin
        width_q[i] <= DefaultWidth;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CHANNEL_COUNT: chan_count_q   <= cfg_data_i[ChIdxW-1:0];
        REG_FRAME_PERIOD:  frame_period_q <= cfg_data_i;
        REG_WIDTH_CH0:     width_q[0]     <= cfg_data_i;
        REG_WIDTH_CH1:     width_q[1]     <= cfg_data_i;
        REG_WIDTH_CH2:     width_q[2]     <= cfg_data_i;
        REG_WIDTH_CH3:     width_q[3]     <= cfg_data_i;
        REG_WIDTH_CH4:     width_q[4]     <= cfg_data_i;
        REG_WIDTH_CH5:     width_q[5]     <= cfg_data_i;
        default:           chan_count_q   <= chan_count_q;
      endcase
    end
  end

  // sequencer state
  logic [COUNTER_BITS-1:0] frame_cnt_q, frame_cnt_d;
  logic [COUNTER_BITS-1:0] pulse_cnt_q, pulse_cnt_d;
  logic [ChIdxW-1:0]       chan_idx_q, chan_idx_d;
  logic [LineW-1:0]        lines_q, lines_d;
  logic                    done_q, done_d;
  logic                    frame_start;

  // output stage: result register plus skid entry
  result_t out_q, skid_q, result;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    in_fire, out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // effective period: zero reads as one, capped at 2^COUNTER_BITS
  logic [ExtW-1:0] period_ext, period_eff, frame_next;
  assign period_ext = (frame_period_q == '0) ? ExtW'(1) : ExtW'(frame_period_q);
  assign period_eff = (period_ext > CntCap) ? CntCap : period_ext;
  assign frame_next = ExtW'(frame_cnt_q) + ExtW'(1);

  // channels in use, capped at the channels built
  logic [ChIdxW-1:0] used_chans;
  assign used_chans = (chan_count_q > MaxChannels) ? MaxChannels : chan_count_q;

  // next channel and the width it loads; width of channel 0 for a frame start
  logic [ChIdxW:0]         next_idx;
  logic [CfgDataW-1:0]     next_width;
  logic [COUNTER_BITS-1:0] load_first, load_next;

  assign next_idx   = {1'b0, chan_idx_q} + (ChIdxW+1)'(1);
  assign next_width = (next_idx < (ChIdxW+1)'(NumWidthRegs))
                      ? width_q[next_idx[ChIdxW-1:0]] : '0;

  // ticks left after the first one: max(width,1) capped at 2^COUNTER_BITS, minus one
  function automatic logic [COUNTER_BITS-1:0] pulse_load(input logic [CfgDataW-1:0] w);
    logic [ExtW-1:0] wz;
    logic [ExtW-1:0] wc;
    wz = (w == '0) ? ExtW'(1) : ExtW'(w);
    wc = (wz > CntCap) ? CntCap : wz;
    return COUNTER_BITS'(wc - ExtW'(1));
  endfunction

  assign load_first = pulse_load(width_q[0]);
  assign load_next  = pulse_load(next_width);

  always_comb begin
    frame_cnt_d = frame_cnt_q;
    pulse_cnt_d = pulse_cnt_q;
    chan_idx_d  = chan_idx_q;
    lines_d     = lines_q;
    done_d      = done_q;
    frame_start = 1'b0;
    if (tick_i) begin
      frame_start = (frame_cnt_q == '0);
      frame_cnt_d = (frame_next >= period_eff) ? '0 : frame_next[COUNTER_BITS-1:0];
      if (frame_start) begin
        // a frame start cuts short whatever pulse is still running
        chan_idx_d = '0;
        if (used_chans == '0) begin
          lines_d     = '0;
          done_d      = 1'b1;
          pulse_cnt_d = '0;
        end else begin
          lines_d     = LineW'(1);
          done_d      = 1'b0;
          pulse_cnt_d = load_first;
        end
      end else if (!done_q) begin
        if (pulse_cnt_q == '0) begin
          // pulse expired: hand over to the next channel or end the train
          lines_d = '0;
          if (next_idx < {1'b0, used_chans}) begin
            chan_idx_d  = next_idx[ChIdxW-1:0];
            lines_d     = LineW'(1) << next_idx[ChIdxW-1:0];
            pulse_cnt_d = load_next;
          end else begin
            done_d = 1'b1;
          end
        end else begin
          pulse_cnt_d = pulse_cnt_q - COUNTER_BITS'(1);
        end
      end
    end
  end

  // result shows the state after the update
  always_comb begin
    result.servo_lines    = lines_d;
    result.active_channel = chan_idx_d;
    result.frame_start    = frame_start;
    result.train_done     = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q <= '0;
      pulse_cnt_q <= '0;
      chan_idx_q  <= '0;
      lines_q     <= '0;
      done_q      <= 1'b1;
    end else if (in_fire) begin
      frame_cnt_q <= frame_cnt_d;
      pulse_cnt_q <= pulse_cnt_d;
      chan_idx_q  <= chan_idx_d;
      lines_q     <= lines_d;
      done_q      <= done_d;
    end
  end

  // output stage control
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      out_valid_d  = skid_valid_q || in_fire;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_lines_o    = out_q.servo_lines;
  assign active_channel_o = out_q.active_channel;
  assign frame_start_o    = out_q.frame_start;
  assign train_done_o     = out_q.train_done;

endmodule

// ===== src/sps_checker.sv =====
// sps_checker: port-level checks of servo_pulse_sequencer, bound into every instance of it
// depends on sps_pkg
module sps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic [sps_pkg::LineW-1:0]   servo_lines_o,
  input logic [sps_pkg::ChIdxW-1:0]  active_channel_o,
  input logic                        frame_start_o,
  input logic                        train_done_o
);
  import sps_pkg::*;

  // input backs up only behind a full output register
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // at most one servo line high at a time
  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(servo_lines_o))
    else $error("more than one servo line high");

  // the high line is the active channel
  a_line_matches_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && servo_lines_o != '0) |->
      servo_lines_o == (LineW'(1) << active_channel_o))
    else $error("high line differs from active channel");

  // a finished train drives no line
  a_done_lines_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && train_done_o) |-> servo_lines_o == '0)
    else $error("line high after train done");

  // a frame always restarts at channel 0
  a_frame_starts_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_start_o) |-> active_channel_o == '0)
    else $error("frame start not on channel 0");

endmodule

bind servo_pulse_sequencer sps_checker u_sps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .servo_lines_o    (servo_lines_o),
  .active_channel_o (active_channel_o),
  .frame_start_o    (frame_start_o),
  .train_done_o     (train_done_o)
);
